### src/icmr_pkg.sv
// Shared types and constants of the int8 convolution MAC and requantize block.
package icmr_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_IN_OFF    = 3'd0;
    localparam logic [2:0] CFG_W_OFF     = 3'd1;
    localparam logic [2:0] CFG_RES_OFF   = 3'd2;
    localparam logic [2:0] CFG_CLAMP_LO  = 3'd3;
    localparam logic [2:0] CFG_CLAMP_HI  = 3'd4;

    // Reset values of the clamp bounds
    localparam logic signed [7:0] CLAMP_LO_RST = -8'sd128;
    localparam logic signed [7:0] CLAMP_HI_RST = 8'sd127;

    // Rounding constant added before the Q31 shift
    localparam logic signed [63:0] ROUND_HALF = 64'sd1073741824;

    // Requantize request: finished accumulator and channel scale
    typedef struct packed {
        logic signed [31:0] acc;
        logic signed [31:0] mult;
        logic signed [5:0]  shift;
    } t_req;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Offsets used by the MAC front
    typedef struct packed {
        logic signed [8:0] in_off;
        logic signed [8:0] w_off;
    } t_front_cfg;

    // Output stage settings used by the requantize back
    typedef struct packed {
        logic signed [7:0] res_off;
        logic signed [7:0] clamp_lo;
        logic signed [7:0] clamp_hi;
    } t_back_cfg;

    // Requantize sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_RND,
        BK_SHF,
        BK_CLP
    } t_back_state;

endpackage

### src/icmr_front.sv
// MAC front: offset add, 10x10 multiply, 32-bit wrapping accumulate, request push.
module icmr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic signed [7:0]        i_activation,
    input  logic                     i_in_bounds,
    input  logic signed [7:0]        i_weight_byte,
    input  logic                     i_first_tap,
    input  logic                     i_last_tap,
    input  logic signed [31:0]       i_bias_value,
    input  logic signed [31:0]       i_channel_multiplier,
    input  logic signed [5:0]        i_channel_shift,
    input  icmr_pkg::t_front_cfg     i_cfg,
    output logic                     o_push,
    output icmr_pkg::t_req           o_req
);

    logic signed [31:0] r_acc;
    logic signed [31:0] n_acc;
    logic signed [9:0]  a_term;
    logic signed [9:0]  b_term;
    logic signed [19:0] prod;
    logic signed [31:0] base;

    // Offset-corrected operands; a padding tap contributes the input offset alone
    always_comb begin
        if (i_in_bounds) begin
            a_term = {{2{i_activation[7]}}, i_activation} + {i_cfg.in_off[8], i_cfg.in_off};
        end else begin
            a_term = {i_cfg.in_off[8], i_cfg.in_off};
        end
        b_term = {{2{i_weight_byte[7]}}, i_weight_byte} + {i_cfg.w_off[8], i_cfg.w_off};
    end

    // Multiply-accumulate, wraps at 32 bits
    assign prod  = a_term * b_term;
    assign base  = i_first_tap ? i_bias_value : r_acc;
    assign n_acc = base + {{12{prod[19]}}, prod};

    // Accumulator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_accept) begin
            r_acc <= n_acc;
        end
    end

    // Last tap hands the finished sum to the requantize queue
    assign o_push     = i_accept & i_last_tap;
    assign o_req.acc  = n_acc;
    assign o_req.mult = i_channel_multiplier;
    assign o_req.shift = i_channel_shift;

endmodule

### src/icmr_queue.sv
// Request queue between the MAC front and the requantize back.
module icmr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  icmr_pkg::t_req        i_data,
    input  logic                  i_pop,
    output icmr_pkg::t_req        o_data,
    output icmr_pkg::t_q_status   o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    icmr_pkg::t_req   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/icmr_back.sv
// Requantize back: Q31 multiply, rounding shift, offset, clamp, result register.
module icmr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  icmr_pkg::t_q_status   i_q_status,
    input  icmr_pkg::t_req        i_req,
    output logic                  o_q_pop,
    input  icmr_pkg::t_back_cfg   i_cfg,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic signed [7:0]     o_quantized_out
);

    icmr_pkg::t_back_state r_state;
    icmr_pkg::t_back_state n_state;

    logic signed [31:0] r_acc;
    logic signed [31:0] r_mult;
    logic signed [5:0]  r_shift;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_x;
    logic signed [32:0] r_y;
    logic signed [7:0]  r_out;
    logic               r_out_valid;

    logic               slot_free;
    logic               load_out;
    logic signed [63:0] prod;
    logic signed [63:0] rnd_sum;
    logic signed [32:0] x_ext;
    logic signed [32:0] rnd_bias;
    logic signed [32:0] x_rnd;
    logic [5:0]         lsh_amt;
    logic [31:0]        x_lsh;
    logic signed [32:0] n_y;
    logic signed [33:0] v_sum;
    logic signed [33:0] v_lo;
    logic signed [33:0] v_clamp;

    assign slot_free = ~r_out_valid | i_pop;

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= icmr_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, queue pop and result load
    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            icmr_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_q_pop = 1'b1;
                    n_state = icmr_pkg::BK_MUL;
                end
            end
            icmr_pkg::BK_MUL: n_state = icmr_pkg::BK_RND;
            icmr_pkg::BK_RND: n_state = icmr_pkg::BK_SHF;
            icmr_pkg::BK_SHF: n_state = icmr_pkg::BK_CLP;
            icmr_pkg::BK_CLP: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = icmr_pkg::BK_IDLE;
                end
            end
            default: n_state = icmr_pkg::BK_IDLE;
        endcase
    end

    // 32x32 signed product
    assign prod = r_acc * r_mult;

    // Round-to-nearest Q31 scaling, truncated to 32 bits
    assign rnd_sum = r_prod + icmr_pkg::ROUND_HALF;

    // Channel shift: positive rounds half up, negative wraps left
    assign x_ext    = {r_x[31], r_x};
    assign rnd_bias = 33'sd1 << (r_shift[4:0] - 5'd1);
    assign x_rnd    = x_ext + rnd_bias;
    assign lsh_amt  = -r_shift;
    assign x_lsh    = r_x << lsh_amt[4:0];

    always_comb begin
        if (!r_shift[5] && (r_shift != '0)) begin
            n_y = x_rnd >>> r_shift[4:0];
        end else if (r_shift[5]) begin
            if (lsh_amt[5]) begin
                n_y = '0;
            end else begin
                n_y = {x_lsh[31], x_lsh};
            end
        end else begin
            n_y = x_ext;
        end
    end

    // Output offset and clamp, low bound first
    assign v_sum   = {r_y[32], r_y} + {{26{i_cfg.res_off[7]}}, i_cfg.res_off};
    assign v_lo    = (v_sum < $signed({{26{i_cfg.clamp_lo[7]}}, i_cfg.clamp_lo}))
                   ? {{26{i_cfg.clamp_lo[7]}}, i_cfg.clamp_lo} : v_sum;
    assign v_clamp = (v_lo > $signed({{26{i_cfg.clamp_hi[7]}}, i_cfg.clamp_hi}))
                   ? {{26{i_cfg.clamp_hi[7]}}, i_cfg.clamp_hi} : v_lo;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_acc   <= i_req.acc;
            r_mult  <= i_req.mult;
            r_shift <= i_req.shift;
        end
        if (r_state == icmr_pkg::BK_MUL) begin
            r_prod <= prod;
        end
        if (r_state == icmr_pkg::BK_RND) begin
            r_x <= rnd_sum[62:31];
        end
        if (r_state == icmr_pkg::BK_SHF) begin
            r_y <= n_y;
        end
        if (load_out) begin
            r_out <= v_clamp[7:0];
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty         = ~r_out_valid;
    assign o_quantized_out = r_out;

endmodule

### src/int8_conv_mac_requantize_per_channel.sv
// A last tap's sum passes the queue and the back's operand, product, rounded, shifted and
// result registers, the last loaded once free. The front takes one tap per cycle while full
// is low; the back's single 32x32 multiplier runs in five steps, and a new request is popped
// only once the last result is loaded. full rises only while QUEUE_DEPTH requests wait.
// Synchronous active-low reset clears the accumulator, queue, sequencer and config registers.
module int8_conv_mac_requantize_per_channel #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [7:0]  i_activation,
    input  logic               i_in_bounds,
    input  logic signed [7:0]  i_weight_byte,
    input  logic               i_first_tap,
    input  logic               i_last_tap,
    input  logic signed [31:0] i_bias_value,
    input  logic signed [31:0] i_channel_multiplier,
    input  logic signed [5:0]  i_channel_shift,
    output logic               empty,
    input  logic               pop,
    output logic signed [7:0]  o_quantized_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);

    logic signed [8:0] r_in_off;
    logic signed [8:0] r_w_off;
    logic signed [7:0] r_res_off;
    logic signed [7:0] r_clamp_lo;
    logic signed [7:0] r_clamp_hi;

    icmr_pkg::t_front_cfg front_cfg;
    icmr_pkg::t_back_cfg  back_cfg;
    icmr_pkg::t_req       push_req;
    icmr_pkg::t_req       head_req;
    icmr_pkg::t_q_status  q_status;
    logic                 accept;
    logic                 q_push;
    logic                 q_pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_off   <= '0;
            r_w_off    <= '0;
            r_res_off  <= '0;
            r_clamp_lo <= icmr_pkg::CLAMP_LO_RST;
            r_clamp_hi <= icmr_pkg::CLAMP_HI_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                icmr_pkg::CFG_IN_OFF:   r_in_off   <= i_cfg_data;
                icmr_pkg::CFG_W_OFF:    r_w_off    <= i_cfg_data;
                icmr_pkg::CFG_RES_OFF:  r_res_off  <= i_cfg_data[7:0];
                icmr_pkg::CFG_CLAMP_LO: r_clamp_lo <= i_cfg_data[7:0];
                icmr_pkg::CFG_CLAMP_HI: r_clamp_hi <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign front_cfg.in_off   = r_in_off;
    assign front_cfg.w_off    = r_w_off;
    assign back_cfg.res_off   = r_res_off;
    assign back_cfg.clamp_lo  = r_clamp_lo;
    assign back_cfg.clamp_hi  = r_clamp_hi;

    // Input transaction
    assign full   = q_status.full;
    assign accept = push & ~q_status.full;

    icmr_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_activation         (i_activation),
        .i_in_bounds          (i_in_bounds),
        .i_weight_byte        (i_weight_byte),
        .i_first_tap          (i_first_tap),
        .i_last_tap           (i_last_tap),
        .i_bias_value         (i_bias_value),
        .i_channel_multiplier (i_channel_multiplier),
        .i_channel_shift      (i_channel_shift),
        .i_cfg                (front_cfg),
        .o_push               (q_push),
        .o_req                (push_req)
    );

    icmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (push_req),
        .i_pop    (q_pop),
        .o_data   (head_req),
        .o_status (q_status)
    );

    icmr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_req           (head_req),
        .o_q_pop         (q_pop),
        .i_cfg           (back_cfg),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_quantized_out (o_quantized_out)
    );

endmodule

### tb/requant_checker.sv
// Scoreboard for the int8 convolution MAC and requantize block: predicts each result and compares.
module requant_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic signed [7:0]  i_activation,
    input  logic               i_in_bounds,
    input  logic signed [7:0]  i_weight_byte,
    input  logic               i_first_tap,
    input  logic               i_last_tap,
    input  logic signed [31:0] i_bias_value,
    input  logic signed [31:0] i_channel_multiplier,
    input  logic signed [5:0]  i_channel_shift,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [7:0]  i_quantized_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    localparam logic signed [63:0] Q31_HALF = 64'sd1 <<< 30;

    // Shadow copy of the register file and the running sum
    logic signed [8:0] in_off;
    logic signed [8:0] w_off;
    logic signed [7:0] res_off;
    logic signed [7:0] clamp_lo;
    logic signed [7:0] clamp_hi;
    logic [31:0]       mac_sum;

    logic signed [7:0] quantized_expected[$];
    logic signed [7:0] want;
    int                term_a;
    int                term_b;
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] requant_checker: %s", $time, msg);
        fail_count++;
    endtask

    // Q31 rescale, rounding shift, offset and clamp of a finished sum
    function automatic logic signed [7:0] requantize(input logic signed [31:0] acc,
                                                     input logic signed [31:0] mult,
                                                     input logic signed [5:0]  sh);
        logic signed [63:0] wide;
        logic signed [31:0] scaled;
        int                 n;
        wide   = acc;
        wide   = wide * mult;
        wide   = (wide + Q31_HALF) >>> 31;
        scaled = wide[31:0];
        n      = sh;
        if (n > 0) begin
            // round half up, exact in 64 bits
            wide = scaled;
            wide = (wide + (64'sd1 <<< (n - 1))) >>> n;
        end else begin
            // left shift wraps at 32 bits; a shift by 32 clears it
            if (n <= -32)
                scaled = '0;
            else if (n < 0)
                scaled = scaled << (-n);
            wide = scaled;
        end
        wide = wide + res_off;
        if (wide < clamp_lo)
            wide = clamp_lo;
        if (wide > clamp_hi)
            wide = clamp_hi;
        return wide[7:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_off   = '0;
            w_off    = '0;
            res_off  = '0;
            clamp_lo = icmr_pkg::CLAMP_LO_RST;
            clamp_hi = icmr_pkg::CLAMP_HI_RST;
            mac_sum  = '0;
            quantized_expected.delete();
        end else begin
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    icmr_pkg::CFG_IN_OFF:   in_off   = i_cfg_data;
                    icmr_pkg::CFG_W_OFF:    w_off    = i_cfg_data;
                    icmr_pkg::CFG_RES_OFF:  res_off  = i_cfg_data[7:0];
                    icmr_pkg::CFG_CLAMP_LO: clamp_lo = i_cfg_data[7:0];
                    icmr_pkg::CFG_CLAMP_HI: clamp_hi = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // result transaction: compare with the oldest prediction
            if (i_pop && !i_empty) begin
                if (quantized_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no tap pending",
                                              i_quantized_out));
                end else begin
                    want = quantized_expected.pop_front();
                    if (i_quantized_out !== want)
                        report_mismatch($sformatf("quantized_out %0d, expected %0d",
                                                  i_quantized_out, want));
                end
            end

            // tap transaction: accumulate, and predict on a last tap
            if (i_push && !i_full) begin
                term_a  = i_in_bounds ? i_activation + in_off : in_off;
                term_b  = i_weight_byte + w_off;
                mac_sum = (i_first_tap ? i_bias_value : mac_sum) + term_a * term_b;
                if (i_last_tap)
                    quantized_expected.push_back(requantize(mac_sum, i_channel_multiplier,
                                                            i_channel_shift));
            end
        end
        o_outstanding <= quantized_expected.size();
    end

endmodule

### tb/tb_top.sv
// Top of the testbench: clock, reset, tap and register stimulus, result draining, verdict.
module tb_top;

    localparam int RESET_CYCLES    = 6;
    localparam int IDLE_PCT        = 19;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int CFG_INDEX_SPAN  = 8;
    localparam int NOISE_PCT       = 12;

    // One convolution tap as offered to the block
    typedef struct packed {
        logic signed [7:0]  act;
        logic               in_image;
        logic signed [7:0]  wgt;
        logic               first;
        logic               last;
        logic signed [31:0] bias;
        logic signed [31:0] mult;
        logic signed [5:0]  shift;
    } t_tap_item;

    logic               i_clk                = 1'b0;
    logic               i_rst_n              = 1'b0;
    logic               push                 = 1'b0;
    logic               full;
    logic signed [7:0]  i_activation         = '0;
    logic               i_in_bounds          = 1'b0;
    logic signed [7:0]  i_weight_byte        = '0;
    logic               i_first_tap          = 1'b0;
    logic               i_last_tap           = 1'b0;
    logic signed [31:0] i_bias_value         = '0;
    logic signed [31:0] i_channel_multiplier = '0;
    logic signed [5:0]  i_channel_shift      = '0;
    logic               empty;
    logic               pop                  = 1'b0;
    logic signed [7:0]  o_quantized_out;
    logic               i_cfg_valid          = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index          = '0;
    logic [8:0]         i_cfg_data           = '0;

    int fail_count;
    int outstanding;
    int cycle_count   = 0;
    bit no_gaps       = 1'b0;
    bit hold_off_req  = 1'b0;

    always #10 i_clk = ~i_clk;

    int8_conv_mac_requantize_per_channel u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_activation         (i_activation),
        .i_in_bounds          (i_in_bounds),
        .i_weight_byte        (i_weight_byte),
        .i_first_tap          (i_first_tap),
        .i_last_tap           (i_last_tap),
        .i_bias_value         (i_bias_value),
        .i_channel_multiplier (i_channel_multiplier),
        .i_channel_shift      (i_channel_shift),
        .empty                (empty),
        .pop                  (pop),
        .o_quantized_out      (o_quantized_out),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    requant_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_push               (push),
        .i_full               (full),
        .i_activation         (i_activation),
        .i_in_bounds          (i_in_bounds),
        .i_weight_byte        (i_weight_byte),
        .i_first_tap          (i_first_tap),
        .i_last_tap           (i_last_tap),
        .i_bias_value         (i_bias_value),
        .i_channel_multiplier (i_channel_multiplier),
        .i_channel_shift      (i_channel_shift),
        .i_empty              (empty),
        .i_pop                (pop),
        .i_quantized_out      (o_quantized_out),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_fail_count         (fail_count),
        .o_outstanding        (outstanding)
    );

    function automatic t_tap_item make_tap(input logic signed [7:0] act, input logic in_image,
                                           input logic signed [7:0] wgt, input logic first,
                                           input logic last, input logic signed [31:0] bias,
                                           input logic signed [31:0] mult,
                                           input logic signed [5:0] shift);
        t_tap_item t;
        t.act      = act;
        t.in_image = in_image;
        t.wgt      = wgt;
        t.first    = first;
        t.last     = last;
        t.bias     = bias;
        t.mult     = mult;
        t.shift    = shift;
        return t;
    endfunction

    // Random tap content; scale and bias mostly in ranges that give unclamped outputs
    function automatic t_tap_item random_tap();
        t_tap_item t;
        t.act      = 8'($urandom);
        t.in_image = ($urandom_range(99) < 85);
        t.wgt      = 8'($urandom);
        t.first    = 1'($urandom);
        t.last     = 1'($urandom);
        case ($urandom_range(3))
            0:       t.bias = $urandom;
            1:       t.bias = $urandom_range(2047) - 1024;
            2:       t.bias = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: t.bias = $urandom_range(2097151) - 1048576;
        endcase
        if ($urandom_range(3) == 0)
            t.mult = $urandom;
        else
            t.mult = $urandom_range(32'h7fff_ffff, 32'h4000_0000);
        case ($urandom_range(9))
            0, 1:    t.shift = 6'($urandom);
            2:       t.shift = 6'(0 - $urandom_range(4, 1));
            default: t.shift = 6'($urandom_range(14));
        endcase
        return t;
    endfunction

    // Offer one tap; push stays high into the next tap unless a gap is drawn
    task automatic send_tap(input t_tap_item t);
        if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_activation         <= t.act;
        i_in_bounds          <= t.in_image;
        i_weight_byte        <= t.wgt;
        i_first_tap          <= t.first;
        i_last_tap           <= t.last;
        i_bias_value         <= t.bias;
        i_channel_multiplier <= t.mult;
        i_channel_shift      <= t.shift;
        push                 <= 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering, wait for every result, then let the pipeline empty
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; caller lowers valid after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic [8:0] in_off, input logic [8:0] w_off,
                              input logic [7:0] res_off, input logic [7:0] lo,
                              input logic [7:0] hi, input bit spare);
        wait_idle();
        write_reg(icmr_pkg::CFG_IN_OFF, in_off);
        write_reg(icmr_pkg::CFG_W_OFF, w_off);
        // bit 8 is don't-care for the 8-bit registers
        write_reg(icmr_pkg::CFG_RES_OFF, {1'($urandom), res_off});
        if (spare) begin
            // unmapped indexes must be ignored
            for (int idx = icmr_pkg::CFG_CLAMP_HI + 1; idx < CFG_INDEX_SPAN; idx++)
                write_reg(3'(idx), 9'($urandom));
        end
        write_reg(icmr_pkg::CFG_CLAMP_LO, {1'($urandom), lo});
        write_reg(icmr_pkg::CFG_CLAMP_HI, {1'($urandom), hi});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_random_config();
        set_config(9'($urandom), 9'($urandom), 8'($urandom), 8'(0 - $urandom_range(128)),
                   8'($urandom_range(127)), 1'($urandom));
    endtask

    // Mostly first..last runs with random content, some loose taps mixed in
    task automatic run_random(input int n_taps, input int max_len);
        t_tap_item t;
        int        sent;
        int        len;
        sent = 0;
        while (sent < n_taps) begin
            if ($urandom_range(99) < NOISE_PCT) begin
                send_tap(random_tap());
                sent++;
            end else begin
                len = $urandom_range(max_len, 1);
                for (int k = 0; k < len; k++) begin
                    t       = random_tap();
                    t.first = (k == 0);
                    t.last  = (k == len - 1);
                    send_tap(t);
                end
                sent += len;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                pop <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed taps under reset settings
        send_tap(make_tap(8'sd127, 1'b1, -8'sd128, 1'b0, 1'b1, 0, 32'h7fff_ffff, 6'sd0));
        send_tap(make_tap(-8'sd128, 1'b1, -8'sd128, 1'b1, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff,
                          6'sd0));
        send_tap(make_tap(8'sd0, 1'b1, 8'sd0, 1'b0, 1'b1, 0, 32'h8000_0000, 6'sd0));
        send_tap(make_tap(-8'sd128, 1'b0, 8'sd127, 1'b1, 1'b0, 32'h8000_0000, 0, 6'sd0));
        send_tap(make_tap(8'sd127, 1'b1, 8'sd127, 1'b0, 1'b1, 0, 32'h4000_0000, 6'sd31));
        send_tap(make_tap(8'sd3, 1'b1, 8'sd5, 1'b1, 1'b1, 32'd12345, 32'h7fff_ffff, -6'sd31));
        // shift of minus 32 clears the value
        send_tap(make_tap(8'sd1, 1'b1, 8'sd1, 1'b1, 1'b1, 32'd1, 32'h7fff_ffff, 6'b100000));
        // exact half rounds up
        send_tap(make_tap(8'sd0, 1'b1, 8'sd0, 1'b1, 1'b1, 32'd3, 32'h4000_0000, 6'sd1));
        send_tap(make_tap(8'sd10, 1'b1, -8'sd10, 1'b1, 1'b0, -32'sd500, 0, 6'sd0));
        send_tap(make_tap(-8'sd7, 1'b1, 8'sd9, 1'b0, 1'b0, 0, 0, 6'sd0));
        send_tap(make_tap(8'sd0, 1'b0, 8'sd0, 1'b0, 1'b1, 0, 32'h7fff_ffff, -6'sd3));

        // offsets at the out-of-range minimum
        set_config(9'h100, 9'h100, 8'sd127, -8'sd128, 8'sd127, 1'b0);
        send_tap(make_tap(-8'sd128, 1'b1, -8'sd128, 1'b1, 1'b1, 0, 32'd1, 6'sd0));
        send_tap(make_tap(8'sd127, 1'b0, 8'sd127, 1'b1, 1'b1, -32'sd200000, 32'h7fff_ffff,
                          6'sd4));
        send_tap(make_tap(8'sd127, 1'b1, 8'sd127, 1'b1, 1'b1, 0, 32'h8000_0000, -6'sd1));

        // clamp_low above clamp_high
        set_config(9'sd255, 9'sd255, -8'sd128, 8'sd10, -8'sd10, 1'b1);
        send_tap(make_tap(8'sd127, 1'b1, 8'sd127, 1'b1, 1'b1, 0, 32'h4000_0000, 6'sd8));
        send_tap(make_tap(-8'sd128, 1'b0, -8'sd128, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000,
                          6'sd0));

        // random phases across settings
        set_config(9'sd255, -9'sd255, 8'sd127, -8'sd128, 8'sd127, 1'b0);
        run_random(100, 6);

        set_config(9'h100, 9'sd255, -8'sd128, 8'sd50, -8'sd20, 1'b1);
        run_random(90, 6);

        // back-pressure: results held off while short runs keep coming
        set_random_config();
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
        run_random(60, 2);
        no_gaps      = 1'b0;
        run_random(60, 6);

        // long stretch with no idling on either side
        set_config(9'sd0, 9'sd0, 8'sd0, -8'sd128, 8'sd127, 1'b0);
        no_gaps = 1'b1;
        run_random(100, 8);
        no_gaps = 1'b0;

        set_random_config();
        run_random(100, 4);

        set_random_config();
        run_random(100, 6);

        wait_idle();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
